@@ rtl/itp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and operator helpers for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int CHAR_W          = 8;

  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_DIG_0  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIG_9  = 8'h39;

  typedef enum logic [1:0] {
    STK_HOLD = 2'd0,
    STK_PUSH = 2'd1,
    STK_POP  = 2'd2
  } stk_op_t;

  typedef struct packed {
    stk_op_t           op;
    logic [CHAR_W-1:0] data;
  } stk_cmd_t;

  function automatic logic is_operand(input logic [CHAR_W-1:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
           ((c >= CH_DIG_0) && (c <= CH_DIG_9));
  endfunction

  function automatic logic [1:0] prec_of(input logic [CHAR_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_CARET) begin
      p = 2'd3;
    end else if ((c == CH_STAR) || (c == CH_SLASH)) begin
      p = 2'd2;
    end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
      p = 2'd1;
    end
    return p;
  endfunction

  // true when the stacked operator leaves before the incoming one
  function automatic logic pops_before(input logic [CHAR_W-1:0] top_c,
                                       input logic [CHAR_W-1:0] new_c);
    logic [1:0] pt;
    logic [1:0] pc;
    pt = prec_of(top_c);
    pc = prec_of(new_c);
    return (pt > pc) || ((pt == pc) && (new_c != CH_CARET));
  endfunction

endpackage

@@ rtl/itp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_in_if
// Input channel: one infix character per beat with an end of expression mark.
// ----------------------------------------------------------------------------
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_expression;

  modport source (output valid, output in_char, output end_of_expression, input ready);
  modport sink   (input valid, input in_char, input end_of_expression, output ready);
endinterface

@@ rtl/itp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_out_if
// Output channel: one postfix character per beat, flagged on the last beat
// of a run.
// ----------------------------------------------------------------------------
interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

@@ rtl/itp_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_cell
// One entry of the shifting operator stack. A push takes the entry above,
// a pop takes the entry below.
// ----------------------------------------------------------------------------
module itp_cell
  import itp_pkg::*;
(
  input  logic              clk,
  input  stk_cmd_t          cmd,
  input  logic [CHAR_W-1:0] from_above,
  input  logic [CHAR_W-1:0] from_below,
  output logic [CHAR_W-1:0] data
);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      STK_PUSH: data <= from_above;
      STK_POP:  data <= from_below;
      default:  data <= data;
    endcase
  end

endmodule

@@ rtl/itp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer for the converter: takes a character, steers the stack cells one
// action per cycle unless output backpressure stalls it, and loads the output register.
// ----------------------------------------------------------------------------
module itp_ctrl
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  itp_in_if.sink            in_item,
  itp_out_if.source         out_item,
  input  logic [CHAR_W-1:0] top_char,
  input  logic [CHAR_W-1:0] next_char,
  output stk_cmd_t          cmd
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MAIN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  state_t            end_state;
  logic [CHAR_W-1:0] cur_char;
  logic              cur_eoe;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [CNT_W-1:0]  cnt_m1;
  logic              ovalid;
  logic [CHAR_W-1:0] ochar;
  logic              olast;
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic              can_emit;
  logic              nonempty;
  logic              full;
  logic              top_lp;
  logic              next_lp;
  logic              more_r;
  logic              more_o;

  assign in_item.ready        = (state == S_IDLE);
  assign out_item.valid       = ovalid;
  assign out_item.out_char    = ochar;
  assign out_item.last_of_run = olast;

  assign can_emit  = !ovalid || out_item.ready;
  assign nonempty  = (cnt != '0);
  assign full      = (cnt == CNT_W'(STACK_DEPTH));
  assign cnt_m1    = cnt - CNT_W'(1);
  assign top_lp    = (top_char == CH_LPAREN);
  assign next_lp   = (next_char == CH_LPAREN);
  assign end_state = cur_eoe ? S_FLUSH : S_IDLE;

  // lookahead: does another beat follow this pop
  assign more_r = ((cnt_m1 != '0) && !next_lp) ||
                  (cur_eoe && next_lp && (cnt_m1 > CNT_W'(1)));
  assign more_o = ((cnt_m1 != '0) && !next_lp && pops_before(next_char, cur_char)) ||
                  cur_eoe;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = STK_HOLD;
    cmd.data   = cur_char;
    emit       = 1'b0;
    emit_char  = top_char;
    emit_last  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_item.valid) begin
          state_next = S_MAIN;
        end
      end
      S_MAIN: begin
        if (is_operand(cur_char)) begin
          if (can_emit) begin
            emit       = 1'b1;
            emit_char  = cur_char;
            emit_last  = !(cur_eoe && nonempty);
            state_next = end_state;
          end
        end else if (cur_char == CH_LPAREN) begin
          if (!full) begin
            cmd.op   = STK_PUSH;
            cnt_next = cnt + CNT_W'(1);
          end
          state_next = end_state;
        end else if (cur_char == CH_RPAREN) begin
          if (nonempty && !top_lp) begin
            if (can_emit) begin
              cmd.op    = STK_POP;
              cnt_next  = cnt_m1;
              emit      = 1'b1;
              emit_last = !more_r;
            end
          end else if (nonempty) begin
            cmd.op     = STK_POP;
            cnt_next   = cnt_m1;
            state_next = end_state;
          end else begin
            state_next = end_state;
          end
        end else begin
          if (nonempty && !top_lp && pops_before(top_char, cur_char)) begin
            if (can_emit) begin
              cmd.op    = STK_POP;
              cnt_next  = cnt_m1;
              emit      = 1'b1;
              emit_last = !more_o;
            end
          end else begin
            if (!full) begin
              cmd.op   = STK_PUSH;
              cnt_next = cnt + CNT_W'(1);
            end
            state_next = end_state;
          end
        end
      end
      S_FLUSH: begin
        if (nonempty) begin
          if (can_emit) begin
            cmd.op    = STK_POP;
            cnt_next  = cnt_m1;
            emit      = 1'b1;
            emit_last = (cnt == CNT_W'(1));
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (emit) begin
        ovalid <= 1'b1;
      end else if (out_item.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_item.valid) begin
      cur_char <= in_item.in_char;
      cur_eoe  <= in_item.end_of_expression;
    end
    if (emit) begin
      ochar <= emit_char;
      olast <= emit_last;
    end
  end

endmodule

@@ rtl/infix_to_postfix_converter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard infix to postfix converter built on a row of shifting stack
// cells.
// ----------------------------------------------------------------------------
// One character is taken per beat and its postfix characters leave one per
// beat, the final one flagged by last_of_run. The operator stack is a row of
// STACK_DEPTH cells that all shift together, so the sequencer does one push,
// pop or emitted character at a time: it takes an item in only while idle,
// pops each entry that must leave, then ends the item with a step that emits
// an operand, pushes, discards the matching '(' or finds the stack empty, and
// when the item ends an expression, it pops every entry left on the stack and
// then returns to idle. A push onto a full stack is dropped; output
// backpressure simply stalls the sequencer.
module infix_to_postfix_converter_unit
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  itp_in_if.sink    in_item,
  itp_out_if.source out_item
);

  stk_cmd_t          cmd;
  logic [CHAR_W-1:0] cell_q [STACK_DEPTH];

  itp_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_item  (out_item),
    .top_char  (cell_q[0]),
    .next_char (cell_q[1]),
    .cmd       (cmd)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [CHAR_W-1:0] above;
    logic [CHAR_W-1:0] below;
    if (i == 0) begin : g_head
      assign above = cmd.data;
    end else begin : g_body
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = '0;
    end else begin : g_link
      assign below = cell_q[i+1];
    end
    itp_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .from_above (above),
      .from_below (below),
      .data       (cell_q[i])
    );
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shunting-yard infix to postfix converter.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own operator stack. It turns every accepted
// input character into the postfix characters that the block must return.
// Every output beat is compared with the oldest of those, field by field.
// Stimulus starts with a short directed list. Then comes a deep stack run
// that overflows the stack while the output is held off for a long time.
// After that come random expressions with some noise bytes. Both sides stall
// in random bursts, and the final stretch has no stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import itp_pkg::*;

  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    char_t ch;
    logic  last;
  } postfix_beat_t;

  localparam char_t CH_SPACE = 8'h20;

  class postfix_scoreboard;
    char_t         op_stack [STACK_DEPTH_DEF];
    int unsigned   depth_used;
    postfix_beat_t expected_q [$];
    int            errors;

    function new();
      depth_used = 0;
      errors     = 0;
    endfunction

    function bit is_alnum(char_t c);
      return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
             (c >= CH_DIG_0 && c <= CH_DIG_9);
    endfunction

    function int unsigned rank_of(char_t c);
      if (c == CH_CARET) return 3;
      if (c == CH_STAR || c == CH_SLASH) return 2;
      if (c == CH_PLUS || c == CH_MINUS) return 1;
      return 0;
    endfunction

    function void push_op(char_t c);
      if (depth_used < STACK_DEPTH_DEF) begin
        op_stack[depth_used] = c;
        depth_used++;
      end
    endfunction

    function postfix_beat_t pop_op();
      postfix_beat_t b;
      depth_used--;
      b.ch   = op_stack[depth_used];
      b.last = 1'b0;
      return b;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("error @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // one accepted input beat -> its run of postfix beats
    function void note_char(char_t c, logic eoe);
      postfix_beat_t run [$];
      postfix_beat_t b;
      int unsigned   pc;
      bit            right_assoc;
      if (is_alnum(c)) begin
        b.ch   = c;
        b.last = 1'b0;
        run.push_back(b);
      end else if (c == CH_LPAREN) begin
        push_op(c);
      end else if (c == CH_RPAREN) begin
        while (depth_used > 0 && op_stack[depth_used-1] != CH_LPAREN) run.push_back(pop_op());
        if (depth_used > 0) depth_used--;
      end else begin
        pc          = rank_of(c);
        right_assoc = (c == CH_CARET);
        while (depth_used > 0 && op_stack[depth_used-1] != CH_LPAREN &&
               (rank_of(op_stack[depth_used-1]) > pc ||
                (rank_of(op_stack[depth_used-1]) == pc && !right_assoc)))
          run.push_back(pop_op());
        push_op(c);
      end
      if (eoe) begin
        while (depth_used > 0) run.push_back(pop_op());
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) expected_q.push_back(run[i]);
    endfunction

    task check_result(char_t ch, logic last);
      postfix_beat_t b;
      if (expected_q.size() == 0) begin
        report($sformatf("output beat 0x%02h with nothing expected", ch));
      end else begin
        b = expected_q.pop_front();
        if (ch !== b.ch)
          report($sformatf("out_char 0x%02h, expected 0x%02h", ch, b.ch));
        if (last !== b.last)
          report($sformatf("last_of_run %0b on 0x%02h, expected %0b", last, ch, b.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  itp_in_if  in_bus ();
  itp_out_if out_bus ();

  postfix_scoreboard sb = new();

  bit src_idle   = 1'b1;
  bit sink_idle  = 1'b1;
  bit long_hold  = 1'b0;
  int items_sent = 0;

  infix_to_postfix_converter_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_bus),
    .out_item (out_bus)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // output side: random stalls and one long hold-off
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_bus.ready <= 1'b0;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready)
      sb.check_result(out_bus.out_char, out_bus.last_of_run);
  end

  task automatic send_beat(input char_t c, input logic eoe);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_bus.valid             <= 1'b1;
    in_bus.in_char           <= c;
    in_bus.end_of_expression <= eoe;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_char(c, eoe);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(char_t'(s[i]), i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic char_t pick_operand();
    case ($urandom_range(0, 2))
      0:       return CH_LO_A + char_t'($urandom_range(0, 25));
      1:       return CH_UP_A + char_t'($urandom_range(0, 25));
      default: return CH_DIG_0 + char_t'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic char_t pick_operator();
    case ($urandom_range(0, 6))
      0:       return CH_CARET;
      1:       return CH_STAR;
      2:       return CH_SLASH;
      3:       return CH_PLUS;
      4:       return CH_MINUS;
      5:       return CH_SPACE;
      default: return char_t'($urandom_range(128, 255));
    endcase
  endfunction

  // well-formed expression with random content, sometimes broken by noise
  task automatic send_random_expr();
    char_t toks [$];
    int    n_terms;
    int    open;
    int    pos;
    n_terms = $urandom_range(1, 6);
    open    = 0;
    for (int t = 0; t < n_terms; t++) begin
      while ($urandom_range(0, 3) == 0) begin
        toks.push_back(CH_LPAREN);
        open++;
      end
      toks.push_back(pick_operand());
      if (open > 0 && $urandom_range(0, 2) == 0) begin
        toks.push_back(CH_RPAREN);
        open--;
      end
      if (t != n_terms - 1) toks.push_back(pick_operator());
    end
    if ($urandom_range(0, 7) != 0) begin
      while (open > 0) begin
        toks.push_back(CH_RPAREN);
        open--;
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(0, toks.size());
      if ($urandom_range(0, 1) == 0) toks.insert(pos, char_t'($urandom_range(0, 255)));
      else toks.insert(pos, CH_RPAREN);
    end
    foreach (toks[i])
      send_beat(toks[i], (i == toks.size() - 1) && ($urandom_range(0, 7) != 0));
  endtask

  initial begin
    in_bus.valid             <= 1'b0;
    in_bus.in_char           <= '0;
    in_bus.end_of_expression <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: precedence, parens, right-assoc caret, stray ')', odd bytes
    send_text("a+b*c");
    send_text("(A-Z)/9^0^z");
    send_text("1-2)");
    send_beat(CH_DIG_0 + 8'd5, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(CH_LPAREN, 1'b1);
    wait_drained();

    // overflow the stack while the output is held off
    long_hold = 1'b1;
    repeat (STACK_DEPTH_DEF + 1) send_beat(CH_LPAREN, 1'b0);
    send_beat(CH_UP_A + 8'd16, 1'b1);
    send_text("Z9m0n1");
    wait_drained();

    while (items_sent < 270) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      send_random_expr();
    end
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    while (items_sent < 310) send_random_expr();
    send_beat(CH_SPACE, 1'b1);

    wait_drained();
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
